// ===== hw/rtl/t2ls_pkg.sv =====
// ----------------------------------------------------------------------------
// t2ls_pkg
// Types and constants shared by the Thumb-2 load/store decoder files.
// ----------------------------------------------------------------------------
package t2ls_pkg;

    typedef enum logic [2:0] {
        CMD_STORE = 3'd0,
        CMD_BYTE  = 3'd1,
        CMD_HALF  = 3'd2,
        CMD_WORD  = 3'd3,
        CMD_DUAL  = 3'd4
    } cmd_t;

    typedef enum logic [2:0] {
        HND_UNDEF  = 3'd0,
        HND_HINT   = 3'd1,
        HND_SINGLE = 3'd2,
        HND_EXT    = 3'd3,
        HND_TBB    = 3'd4,
        HND_LDREX  = 3'd5,
        HND_STREX  = 3'd6,
        HND_DUAL   = 3'd7
    } handler_t;

    localparam logic [1:0] EXT_NONE = 2'd0;
    localparam logic [1:0] EXT_UH   = 2'd1;
    localparam logic [1:0] EXT_SB   = 2'd2;
    localparam logic [1:0] EXT_SH   = 2'd3;

    localparam logic [2:0] MODE_OFFSET = 3'b110;
    localparam logic [3:0] REG_PC      = 4'hF;

    localparam logic [11:0] HD_STR_I12  = 12'hF8C;
    localparam logic [11:0] HD_STRB_I12 = 12'hF88;
    localparam logic [11:0] HD_STRH_I12 = 12'hF8A;
    localparam logic [11:0] HD_STR_I8   = 12'hF84;
    localparam logic [11:0] HD_STRB_I8  = 12'hF80;
    localparam logic [11:0] HD_STRH_I8  = 12'hF82;
    localparam logic [11:0] HD_LDRB_I12 = 12'hF89;
    localparam logic [11:0] HD_LDSB_I12 = 12'hF99;
    localparam logic [11:0] HD_LDRB_I8  = 12'hF81;
    localparam logic [11:0] HD_LDSB_I8  = 12'hF91;
    localparam logic [11:0] HD_LDRH_I12 = 12'hF8B;
    localparam logic [11:0] HD_LDSH_I12 = 12'hF9B;
    localparam logic [11:0] HD_LDRH_I8  = 12'hF83;
    localparam logic [11:0] HD_LDSH_I8  = 12'hF93;
    localparam logic [11:0] HD_LDR_I12  = 12'hF8D;
    localparam logic [11:0] HD_LDR_I8   = 12'hF85;
    localparam logic [11:0] HD_STREX    = 12'hE84;

    localparam logic [31:0] TB_MASK    = 32'hFFF0FFE0;
    localparam logic [31:0] TB_MATCH   = 32'hE8D0F000;
    localparam logic [31:0] LDREX_MASK = 32'hFFF00F00;
    localparam logic [31:0] LDREX_MATCH = 32'hE8500F00;
    localparam logic [31:0] DUAL_MASK  = 32'hFE400000;
    localparam logic [31:0] DUAL_MATCH = 32'hE8400000;

    typedef struct packed {
        logic        pcw;
        logic [12:0] off;
        logic [1:0]  ext;
        logic [3:0]  sh;
        logic [3:0]  rx;
        logic [3:0]  rd;
        logic [3:0]  rn;
        logic        immf;
        logic        narrow;
        logic        load;
        logic [2:0]  mode;
    } dec_data_t;

    typedef struct packed {
        handler_t  handler;
        dec_data_t data;
    } dec_res_t;

    localparam int DATA_W       = $bits(dec_data_t);
    localparam int IN_TDATA_W   = 64;
    localparam int IN_TUSER_W   = 3;
    localparam int OUT_TDATA_W  = ((DATA_W + 7) / 8) * 8;
    localparam int OUT_TUSER_W  = 3;

endpackage

// ===== hw/rtl/thumb2_load_store_decoder.sv =====
// ----------------------------------------------------------------------------
// thumb2_load_store_decoder
// Decoder for 32-bit Thumb-2 load and store instructions.
// ----------------------------------------------------------------------------
// Each request carries one instruction word, its address and the decode table
// to use; the block returns one decoded request per instruction. A request is
// taken into an input register, decoded combinationally and caught in the
// output register, and one request is accepted in every cycle while the
// output side keeps taking results.
module thumb2_load_store_decoder
    import t2ls_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // opcode [31:0], insn_address [63:32]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // cmd [2:0]
    input  logic [IN_TUSER_W-1:0]  s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // index_mode [2:0], is_load [3], narrow_flag [4], imm_form [5],
    // base_reg [9:6], data_reg [13:10], index_reg [17:14],
    // shift_or_second [21:18], ext_kind [23:22], offset [36:24],
    // writes_pc [37], zero fill above
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // handler [2:0]
    output logic [OUT_TUSER_W-1:0] m_axis_tuser
);

    logic        in_valid_reg;
    logic        in_valid_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    cmd_t        cmd_reg;
    logic [31:0] opcode_reg;
    logic [1:0]  addr_lo_reg;
    dec_res_t    res_reg;
    dec_res_t    dec_res;
    logic        out_adv;
    logic        in_take;

    t2ls_decode u_decode (
        .cmd     (cmd_reg),
        .opcode  (opcode_reg),
        .addr_lo (addr_lo_reg),
        .res     (dec_res)
    );

    always_comb
    begin
        out_adv        = !out_valid_reg || m_axis_tready;
        s_axis_tready  = !in_valid_reg || out_adv;
        in_take        = s_axis_tvalid && s_axis_tready;
        in_valid_next  = s_axis_tready ? s_axis_tvalid : in_valid_reg;
        out_valid_next = out_adv ? in_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            cmd_reg     <= cmd_t'(s_axis_tuser);
            opcode_reg  <= s_axis_tdata[31:0];
            addr_lo_reg <= s_axis_tdata[33:32];
        end
        if (in_valid_reg && out_adv)
        begin
            res_reg <= dec_res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W - DATA_W){1'b0}}, res_reg.data};
    assign m_axis_tuser  = res_reg.handler;

endmodule

// ===== hw/rtl/t2ls_decode.sv =====
// ----------------------------------------------------------------------------
// t2ls_decode
// Combinational decode of one registered Thumb-2 memory instruction.
// ----------------------------------------------------------------------------
module t2ls_decode
    import t2ls_pkg::*;
(
    input  cmd_t        cmd,
    input  logic [31:0] opcode,
    input  logic [1:0]  addr_lo,
    output dec_res_t    res
);

    logic [11:0] head;
    logic [3:0]  rn;
    logic [3:0]  rt;
    logic [12:0] imm12;
    logic [12:0] imm8s;
    logic [12:0] lit12;
    logic [12:0] dual_off;
    logic [2:0]  puw;
    logic        reg_f;
    logic        hint;
    handler_t    hnd;
    dec_data_t   d;

    always_comb
    begin
        head     = opcode[31:20];
        rn       = opcode[19:16];
        rt       = opcode[15:12];
        imm12    = {1'b0, opcode[11:0]};
        imm8s    = opcode[9] ? {5'b0, opcode[7:0]} : (13'd0 - {5'b0, opcode[7:0]});
        lit12    = (rn == REG_PC) ? (imm12 - {11'b0, addr_lo}) : imm12;
        dual_off = {3'b0, opcode[7:0], 2'b00};
        puw      = opcode[10:8];
        reg_f    = (opcode[11:6] == 6'd0);
        hint     = (rt == REG_PC);
        hnd      = HND_UNDEF;
        d        = '0;
        d.rn     = rn;
        d.rd     = rt;

        unique case (cmd)
            CMD_STORE:
            begin
                if (head == HD_STR_I12 || head == HD_STRB_I12 || head == HD_STRH_I12)
                begin
                    d.mode = MODE_OFFSET;
                    d.immf = 1'b1;
                    d.off  = imm12;
                    if (head == HD_STRH_I12)
                    begin
                        hnd   = HND_EXT;
                        d.ext = EXT_UH;
                    end
                    else
                    begin
                        hnd      = HND_SINGLE;
                        d.narrow = (head == HD_STRB_I12);
                    end
                end
                else if (head == HD_STR_I8 || head == HD_STRB_I8 || head == HD_STRH_I8)
                begin
                    if (opcode[11])
                    begin
                        d.mode = puw;
                        d.immf = 1'b1;
                        d.off  = imm8s;
                    end
                    else
                    begin
                        d.mode = MODE_OFFSET;
                        d.rx   = opcode[3:0];
                        d.sh   = {2'b00, opcode[5:4]};
                    end
                    if (opcode[11] || reg_f)
                    begin
                        if (head == HD_STRH_I8)
                        begin
                            hnd   = HND_EXT;
                            d.ext = EXT_UH;
                        end
                        else
                        begin
                            hnd      = HND_SINGLE;
                            d.narrow = (head == HD_STRB_I8);
                        end
                    end
                end
            end
            CMD_BYTE:
            begin
                d.load = 1'b1;
                if (hint)
                begin
                    hnd = HND_HINT;
                end
                else if (head == HD_LDRB_I12 || head == HD_LDSB_I12)
                begin
                    d.mode = MODE_OFFSET;
                    d.immf = 1'b1;
                    if (head == HD_LDSB_I12)
                    begin
                        hnd   = HND_EXT;
                        d.ext = EXT_SB;
                        d.off = imm12;
                    end
                    else
                    begin
                        hnd      = HND_SINGLE;
                        d.narrow = 1'b1;
                        d.off    = lit12;
                    end
                end
                else if (head == HD_LDRB_I8 || head == HD_LDSB_I8)
                begin
                    if (opcode[11])
                    begin
                        d.mode = puw;
                        d.immf = 1'b1;
                        d.off  = imm8s;
                    end
                    else
                    begin
                        d.mode = MODE_OFFSET;
                        d.rx   = opcode[3:0];
                        d.sh   = {2'b00, opcode[5:4]};
                    end
                    if (opcode[11] || reg_f)
                    begin
                        if (head == HD_LDSB_I8)
                        begin
                            hnd   = HND_EXT;
                            d.ext = EXT_SB;
                        end
                        else
                        begin
                            hnd      = HND_SINGLE;
                            d.narrow = 1'b1;
                        end
                    end
                end
            end
            CMD_HALF:
            begin
                d.load = 1'b1;
                d.ext  = head[4] ? EXT_SH : EXT_UH;
                if (hint)
                begin
                    hnd = HND_HINT;
                end
                else if (head == HD_LDRH_I12 || head == HD_LDSH_I12)
                begin
                    hnd    = HND_EXT;
                    d.mode = MODE_OFFSET;
                    d.immf = 1'b1;
                    d.off  = imm12;
                end
                else if (head == HD_LDRH_I8 || head == HD_LDSH_I8)
                begin
                    if (opcode[11])
                    begin
                        hnd    = HND_EXT;
                        d.mode = puw;
                        d.immf = 1'b1;
                        d.off  = imm8s;
                    end
                    else if (reg_f)
                    begin
                        hnd    = HND_EXT;
                        d.mode = MODE_OFFSET;
                        d.rx   = opcode[3:0];
                        d.sh   = {2'b00, opcode[5:4]};
                    end
                end
            end
            CMD_WORD:
            begin
                d.load = 1'b1;
                d.pcw  = (rt == REG_PC);
                if (head == HD_LDR_I12)
                begin
                    hnd    = HND_SINGLE;
                    d.mode = MODE_OFFSET;
                    d.immf = 1'b1;
                    d.off  = lit12;
                end
                else if (head == HD_LDR_I8)
                begin
                    if (opcode[11])
                    begin
                        hnd    = HND_SINGLE;
                        d.mode = puw;
                        d.immf = 1'b1;
                        d.off  = imm8s;
                    end
                    else if (reg_f)
                    begin
                        hnd    = HND_SINGLE;
                        d.mode = MODE_OFFSET;
                        d.rx   = opcode[3:0];
                        d.sh   = {2'b00, opcode[5:4]};
                    end
                end
            end
            CMD_DUAL:
            begin
                d.off = dual_off;
                if ((opcode & TB_MASK) == TB_MATCH)
                begin
                    hnd      = HND_TBB;
                    d.rd     = 4'd0;
                    d.off    = '0;
                    d.rx     = opcode[3:0];
                    d.narrow = opcode[4];
                    d.pcw    = 1'b1;
                end
                else if ((opcode & LDREX_MASK) == LDREX_MATCH)
                begin
                    hnd = HND_LDREX;
                end
                else if (head == HD_STREX && opcode[11:8] != REG_PC)
                begin
                    hnd  = HND_STREX;
                    d.rx = rt;
                    d.rd = opcode[11:8];
                end
                else if ((opcode & DUAL_MASK) == DUAL_MATCH)
                begin
                    hnd    = HND_DUAL;
                    d.mode = {opcode[24], opcode[23], opcode[21]};
                    d.load = opcode[20];
                    d.sh   = opcode[11:8];
                end
            end
            default:
            begin
                hnd = HND_UNDEF;
            end
        endcase

        res.handler = hnd;
        res.data    = (hnd == HND_UNDEF || hnd == HND_HINT) ? '0 : d;
    end

endmodule

// ===== hw/rtl/t2ls_checker.sv =====
// ----------------------------------------------------------------------------
// t2ls_checker
// Port-level assertions for the Thumb-2 load/store decoder.
// ----------------------------------------------------------------------------
module t2ls_checker
    import t2ls_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [OUT_TUSER_W-1:0] m_axis_tuser
);

    dec_data_t out_data;

    assign out_data = dec_data_t'(m_axis_tdata[DATA_W-1:0]);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("Result request dropped while stalled.");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) ##1 m_axis_tready |=> m_axis_tvalid)
        else $error("Accepted request did not reach the output in two cycles.");

    a_undef_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == HND_UNDEF || m_axis_tuser == HND_HINT)
        |-> m_axis_tdata == '0)
        else $error("Undefined or hint result carries non-zero fields.");

    a_tbb_pc: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == HND_TBB |-> out_data.pcw && !out_data.load)
        else $error("Table branch result without the PC-write flag.");

    a_dual_align: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == HND_DUAL || m_axis_tuser == HND_LDREX
        || m_axis_tuser == HND_STREX) |-> out_data.off[1:0] == 2'b00)
        else $error("Dual or exclusive offset is not word aligned.");

endmodule

bind thumb2_load_store_decoder t2ls_checker u_t2ls_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== test/t2ls_decode_check_pkg.sv =====
// ----------------------------------------------------------------------------
// t2ls_decode_check_pkg
// Expected-decode tracking for the Thumb-2 load/store decoder testbench.
// ----------------------------------------------------------------------------
// The class works out the decode of every accepted request on its own and
// keeps the results in order. Each returned decode is compared field by field
// with the oldest one still waiting.
package t2ls_decode_check_pkg;

    import t2ls_pkg::*;

    class insn_decode_checker;

        localparam int unsigned MAX_REPORTS = 10;

        dec_res_t    pending_decodes[$];
        dec_res_t    work;
        int unsigned mismatch_count;

        function new();
            mismatch_count = 0;
        endfunction

        function void put_single_imm(logic [31:0] op, bit ld, bit byte_acc,
                                     logic [11:0] imm, logic [2:0] puw);
            work.handler     = HND_SINGLE;
            work.data.mode   = puw;
            work.data.load   = ld;
            work.data.narrow = byte_acc;
            work.data.immf   = 1'b1;
            work.data.rn     = op[19:16];
            work.data.rd     = op[15:12];
            work.data.off    = puw[1] ? {1'b0, imm} : 13'd0 - {1'b0, imm};
            work.data.pcw    = ld && !byte_acc && (op[15:12] == REG_PC);
        endfunction

        function void put_single_reg(logic [31:0] op, bit ld, bit byte_acc);
            work.handler     = HND_SINGLE;
            work.data.mode   = MODE_OFFSET;
            work.data.load   = ld;
            work.data.narrow = byte_acc;
            work.data.immf   = 1'b0;
            work.data.rn     = op[19:16];
            work.data.rd     = op[15:12];
            work.data.rx     = op[3:0];
            work.data.sh     = {2'b00, op[5:4]};
            work.data.pcw    = ld && !byte_acc && (op[15:12] == REG_PC);
        endfunction

        function void put_ext(logic [31:0] op, logic [1:0] kind, bit ld, bit immf,
                              logic [11:0] amount, logic [2:0] puw);
            work.handler   = HND_EXT;
            work.data.ext  = kind;
            work.data.mode = puw;
            work.data.load = ld;
            work.data.immf = immf;
            work.data.rn   = op[19:16];
            work.data.rd   = op[15:12];
            if (immf)
            begin
                work.data.off = puw[1] ? {1'b0, amount} : 13'd0 - {1'b0, amount};
            end
            else
            begin
                work.data.rx = op[3:0];
                work.data.sh = amount[3:0];
            end
        endfunction

        // PC-relative literals are taken from the word-aligned PC.
        function void align_literal(logic [31:0] addr);
            if (work.data.rn == REG_PC)
            begin
                work.data.off = work.data.off - 13'((addr + 32'd4) & 32'd3);
            end
        endfunction

        function void decode_store(logic [31:0] op);
            logic [11:0] head;
            head = op[31:20];
            if (head == 12'hF8C || head == 12'hF88 || head == 12'hF8A)
            begin
                if (head == 12'hF8A)
                    put_ext(op, EXT_UH, 1'b0, 1'b1, op[11:0], 3'b110);
                else
                    put_single_imm(op, 1'b0, head == 12'hF88, op[11:0], 3'b110);
            end
            else if (head == 12'hF84 || head == 12'hF80 || head == 12'hF82)
            begin
                if (op[11])
                begin
                    if (head == 12'hF82)
                        put_ext(op, EXT_UH, 1'b0, 1'b1, {4'h0, op[7:0]}, op[10:8]);
                    else
                        put_single_imm(op, 1'b0, head == 12'hF80, {4'h0, op[7:0]},
                                       op[10:8]);
                end
                else if (op[11:6] == 6'd0)
                begin
                    if (head == 12'hF82)
                        put_ext(op, EXT_UH, 1'b0, 1'b0, {10'd0, op[5:4]}, 3'b110);
                    else
                        put_single_reg(op, 1'b0, head == 12'hF80);
                end
            end
        endfunction

        function void decode_byte(logic [31:0] op, logic [31:0] addr);
            logic [11:0] head;
            head = op[31:20];
            if (op[15:12] == REG_PC)
            begin
                work.handler = HND_HINT;
            end
            else if (head == 12'hF89 || head == 12'hF99)
            begin
                if (head == 12'hF99)
                begin
                    put_ext(op, EXT_SB, 1'b1, 1'b1, op[11:0], 3'b110);
                end
                else
                begin
                    put_single_imm(op, 1'b1, 1'b1, op[11:0], 3'b110);
                    align_literal(addr);
                end
            end
            else if (head == 12'hF81 || head == 12'hF91)
            begin
                if (op[11])
                begin
                    if (head == 12'hF91)
                        put_ext(op, EXT_SB, 1'b1, 1'b1, {4'h0, op[7:0]}, op[10:8]);
                    else
                        put_single_imm(op, 1'b1, 1'b1, {4'h0, op[7:0]}, op[10:8]);
                end
                else if (op[11:6] == 6'd0)
                begin
                    if (head == 12'hF91)
                        put_ext(op, EXT_SB, 1'b1, 1'b0, {10'd0, op[5:4]}, 3'b110);
                    else
                        put_single_reg(op, 1'b1, 1'b1);
                end
            end
        endfunction

        function void decode_half(logic [31:0] op);
            logic [11:0] head;
            logic [1:0]  kind;
            head = op[31:20];
            kind = (head == 12'hF8B || head == 12'hF83) ? EXT_UH : EXT_SH;
            if (op[15:12] == REG_PC)
            begin
                work.handler = HND_HINT;
            end
            else if (head == 12'hF8B || head == 12'hF9B)
            begin
                put_ext(op, kind, 1'b1, 1'b1, op[11:0], 3'b110);
            end
            else if (head == 12'hF83 || head == 12'hF93)
            begin
                if (op[11])
                    put_ext(op, kind, 1'b1, 1'b1, {4'h0, op[7:0]}, op[10:8]);
                else if (op[11:6] == 6'd0)
                    put_ext(op, kind, 1'b1, 1'b0, {10'd0, op[5:4]}, 3'b110);
            end
        endfunction

        function void decode_word(logic [31:0] op, logic [31:0] addr);
            if (op[31:20] == 12'hF8D)
            begin
                put_single_imm(op, 1'b1, 1'b0, op[11:0], 3'b110);
                align_literal(addr);
            end
            else if (op[31:20] == 12'hF85)
            begin
                if (op[11])
                    put_single_imm(op, 1'b1, 1'b0, {4'h0, op[7:0]}, op[10:8]);
                else if (op[11:6] == 6'd0)
                    put_single_reg(op, 1'b1, 1'b0);
            end
        endfunction

        function void decode_dual(logic [31:0] op);
            logic [12:0] imm;
            imm = {3'b000, op[7:0], 2'b00};
            if ((op & 32'hFFF0_FFE0) == 32'hE8D0_F000)
            begin
                work.handler     = HND_TBB;
                work.data.rn     = op[19:16];
                work.data.rx     = op[3:0];
                work.data.narrow = op[4];
                work.data.pcw    = 1'b1;
            end
            else if ((op & 32'hFFF0_0F00) == 32'hE850_0F00)
            begin
                work.handler  = HND_LDREX;
                work.data.rn  = op[19:16];
                work.data.rd  = op[15:12];
                work.data.off = imm;
            end
            else if (op[31:20] == 12'hE84 && op[11:8] != REG_PC)
            begin
                work.handler  = HND_STREX;
                work.data.rn  = op[19:16];
                work.data.rx  = op[15:12];
                work.data.rd  = op[11:8];
                work.data.off = imm;
            end
            else if ((op & 32'hFE40_0000) == 32'hE840_0000)
            begin
                work.handler   = HND_DUAL;
                work.data.mode = {op[24], op[23], op[21]};
                work.data.load = op[20];
                work.data.rn   = op[19:16];
                work.data.rd   = op[15:12];
                work.data.sh   = op[11:8];
                work.data.off  = imm;
            end
        endfunction

        function dec_res_t decode_insn(logic [2:0] cmd, logic [31:0] op, logic [31:0] addr);
            work = '0;
            case (cmd)
                CMD_STORE: decode_store(op);
                CMD_BYTE:  decode_byte(op, addr);
                CMD_HALF:  decode_half(op);
                CMD_WORD:  decode_word(op, addr);
                CMD_DUAL:  decode_dual(op);
                default:   work = '0;
            endcase
            return work;
        endfunction

        function void note_request(logic [2:0] cmd, logic [31:0] op, logic [31:0] addr);
            pending_decodes.push_back(decode_insn(cmd, op, addr));
        endfunction

        function int pending_count();
            return pending_decodes.size();
        endfunction

        function string describe_decode(dec_res_t r);
            return $sformatf({"handler=%0d mode=%0d load=%0d narrow=%0d imm=%0d rn=%0d ",
                              "rd=%0d rx=%0d sh=%0d ext=%0d off=%0d pcw=%0d"},
                             r.handler, r.data.mode, r.data.load, r.data.narrow,
                             r.data.immf, r.data.rn, r.data.rd, r.data.rx, r.data.sh,
                             r.data.ext, $signed(r.data.off), r.data.pcw);
        endfunction

        function void check_result(logic [OUT_TUSER_W-1:0] tuser,
                                   logic [OUT_TDATA_W-1:0] tdata);
            dec_res_t want;
            dec_res_t got;
            string    diffs;
            got.handler = handler_t'(tuser[2:0]);
            got.data    = dec_data_t'(tdata[DATA_W-1:0]);
            if (pending_decodes.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("Unexpected decode with none pending: %s", describe_decode(got));
                return;
            end
            want  = pending_decodes.pop_front();
            diffs = "";
            if (got.handler     !== want.handler)     diffs = {diffs, " handler"};
            if (got.data.mode   !== want.data.mode)   diffs = {diffs, " index_mode"};
            if (got.data.load   !== want.data.load)   diffs = {diffs, " is_load"};
            if (got.data.narrow !== want.data.narrow) diffs = {diffs, " narrow_flag"};
            if (got.data.immf   !== want.data.immf)   diffs = {diffs, " imm_form"};
            if (got.data.rn     !== want.data.rn)     diffs = {diffs, " base_reg"};
            if (got.data.rd     !== want.data.rd)     diffs = {diffs, " data_reg"};
            if (got.data.rx     !== want.data.rx)     diffs = {diffs, " index_reg"};
            if (got.data.sh     !== want.data.sh)     diffs = {diffs, " shift_or_second"};
            if (got.data.ext    !== want.data.ext)    diffs = {diffs, " ext_kind"};
            if (got.data.off    !== want.data.off)    diffs = {diffs, " offset"};
            if (got.data.pcw    !== want.data.pcw)    diffs = {diffs, " writes_pc"};
            if ((tdata >> DATA_W) !== '0)             diffs = {diffs, " zero_fill"};
            if (diffs != "")
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("Decode mismatch in%s\n  expected %s\n  actual   %s", diffs,
                             describe_decode(want), describe_decode(got));
            end
        endfunction

    endclass

endpackage

// ===== test/tb_thumb2_load_store_decoder.sv =====
// ----------------------------------------------------------------------------
// tb_thumb2_load_store_decoder
// Self-checking testbench for the Thumb-2 load/store decoder.
// ----------------------------------------------------------------------------
// A directed set covers every decode table, the hint and literal cases, the
// exclusive and table-branch forms and undefined encodings; then well-formed
// instructions with random fields, mixed with noise, are streamed in bursts.
// The output side stalls on its own pattern, once for a long stretch, and
// every decode is checked against an independent prediction.
module tb_thumb2_load_store_decoder;

    timeunit 1ns;
    timeprecision 1ps;

    import t2ls_pkg::*;
    import t2ls_decode_check_pkg::*;

    localparam int         RANDOM_REQUESTS = 1320;
    localparam int         HOLD_CYCLES     = 300;
    localparam int         DRAIN_CYCLES    = 10;
    localparam logic [2:0] CMD_SPARE_LO    = 3'(CMD_DUAL + 1);
    localparam logic [2:0] CMD_SPARE_HI    = 3'b111;

    logic                   clk;
    logic                   rst_n         = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic [IN_TUSER_W-1:0]  s_axis_tuser  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [OUT_TUSER_W-1:0] m_axis_tuser;

    int                     hold_requests = 0;
    insn_decode_checker     decode_sb;

    thumb2_load_store_decoder u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    task automatic offer_request(logic [2:0] cmd, logic [31:0] op, logic [31:0] addr);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {addr, op};
        s_axis_tuser  = cmd;
        do
            @(posedge clk);
        while (!s_axis_tready);
        decode_sb.note_request(cmd, op, addr);
        @(negedge clk);
    endtask

    task automatic idle_sender(int cycles);
        s_axis_tvalid = 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    task automatic wait_for_decodes();
        s_axis_tvalid = 1'b0;
        while (decode_sb.pending_count() != 0)
            @(negedge clk);
    endtask

    function automatic void pick_random_request(output logic [2:0] cmd,
                                                output logic [31:0] op);
        int          roll;
        logic [3:0]  rn;
        logic [3:0]  rt;
        logic [3:0]  rs;
        logic [11:0] head;
        logic [11:0] low12;
        roll = $urandom_range(0, 99);
        rn   = ($urandom_range(0, 3) == 0) ? REG_PC : 4'($urandom);
        rt   = ($urandom_range(0, 5) == 0) ? REG_PC : 4'($urandom);
        rs   = ($urandom_range(0, 3) == 0) ? REG_PC : 4'($urandom);
        if (roll < 8)
        begin
            cmd = 3'($urandom_range(CMD_STORE, CMD_SPARE_HI));
            op  = $urandom;
        end
        else
        begin
            cmd = 3'($urandom_range(CMD_STORE, CMD_DUAL));
            if (roll < 14)
            begin
                op = $urandom;
            end
            else if (cmd == CMD_DUAL)
            begin
                case ($urandom_range(0, 3))
                    0:       op = {12'hE8D, rn, 4'hF, 7'd0, 5'($urandom)};
                    1:       op = {12'hE85, rn, rt, 4'hF, 8'($urandom)};
                    2:       op = {12'hE84, rn, rt, rs, 8'($urandom)};
                    default: op = ($urandom & ~32'hFE40_0000) | 32'hE840_0000;
                endcase
            end
            else
            begin
                case (cmd)
                    CMD_STORE:
                        case ($urandom_range(0, 5))
                            0:       head = 12'hF8C;
                            1:       head = 12'hF88;
                            2:       head = 12'hF8A;
                            3:       head = 12'hF84;
                            4:       head = 12'hF80;
                            default: head = 12'hF82;
                        endcase
                    CMD_BYTE:
                        case ($urandom_range(0, 3))
                            0:       head = 12'hF89;
                            1:       head = 12'hF99;
                            2:       head = 12'hF81;
                            default: head = 12'hF91;
                        endcase
                    CMD_HALF:
                        case ($urandom_range(0, 3))
                            0:       head = 12'hF8B;
                            1:       head = 12'hF9B;
                            2:       head = 12'hF83;
                            default: head = 12'hF93;
                        endcase
                    default:
                        head = ($urandom_range(0, 1) == 0) ? 12'hF8D : 12'hF85;
                endcase
                case ($urandom_range(0, 2))
                    0:       low12 = 12'($urandom);
                    1:       low12 = {1'b1, 3'($urandom), 8'($urandom)};
                    default: low12 = {6'd0, 6'($urandom)};
                endcase
                op = {head, rn, rt, low12};
            end
        end
    endfunction

    initial
    begin
        int cycles_left;
        int stall_mode;
        int hold_left;
        int holds_done;
        cycles_left = 0;
        stall_mode  = 0;
        hold_left   = 0;
        holds_done  = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_left == 0 && holds_done != hold_requests)
            begin
                holds_done++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready = 1'b0;
            end
            else
            begin
                if (cycles_left == 0)
                begin
                    stall_mode  = $urandom_range(0, 3);
                    cycles_left = $urandom_range(20, 200);
                end
                cycles_left--;
                case (stall_mode)
                    0:       m_axis_tready = 1'b1;
                    1:       m_axis_tready = 1'($urandom_range(0, 1));
                    2:       m_axis_tready = ($urandom_range(0, 9) != 0);
                    default: m_axis_tready = ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            decode_sb.check_result(m_axis_tuser, m_axis_tdata);
    end

    initial
    begin
        logic [2:0]  cmd;
        logic [31:0] op;
        int          burst_left;
        decode_sb = new();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        offer_request(CMD_STORE, 32'hF8CF_FFFF, 32'h0000_0000);
        offer_request(CMD_STORE, 32'hF801_0CFF, 32'h0000_0000);
        offer_request(CMD_STORE, 32'hF823_5038, 32'h0000_0000);
        offer_request(CMD_STORE, 32'hF844_1B04, 32'h0000_0000);
        offer_request(CMD_STORE, 32'hF844_1100, 32'h0000_0000);
        offer_request(CMD_BYTE,  32'hF81F_F000, 32'h0000_0000);
        offer_request(CMD_BYTE,  32'hF89F_2FFF, 32'h0000_1001);
        offer_request(CMD_BYTE,  32'hF99F_2123, 32'h0000_0003);
        offer_request(CMD_BYTE,  32'hF912_3D80, 32'h0000_0000);
        offer_request(CMD_BYTE,  32'hF810_4001, 32'h0000_0000);
        offer_request(CMD_HALF,  32'hF83F_F000, 32'h0000_0000);
        offer_request(CMD_HALF,  32'hF8B5_6ABC, 32'h0000_0000);
        offer_request(CMD_HALF,  32'hF936_7F00, 32'h0000_0000);
        offer_request(CMD_HALF,  32'hF937_8022, 32'h0000_0000);
        offer_request(CMD_WORD,  32'hF8DF_F004, 32'h0000_0002);
        offer_request(CMD_WORD,  32'hF8DF_1000, 32'hFFFF_FFFE);
        offer_request(CMD_WORD,  32'hF85D_F904, 32'h0000_0000);
        offer_request(CMD_WORD,  32'hF850_F03F, 32'h0000_0000);
        offer_request(CMD_DUAL,  32'hE8D3_F005, 32'h0000_0000);
        offer_request(CMD_DUAL,  32'hE8D3_F01A, 32'h0000_0000);
        offer_request(CMD_DUAL,  32'hE854_2F7F, 32'h0000_0000);
        offer_request(CMD_DUAL,  32'hE845_3480, 32'h0000_0000);
        offer_request(CMD_DUAL,  32'hE845_3F80, 32'h0000_0000);
        offer_request(CMD_DUAL,  32'hE9F6_78FF, 32'h0000_0000);
        offer_request(CMD_DUAL,  32'h0000_0000, 32'h0000_0000);
        offer_request(CMD_SPARE_LO, 32'hF8CF_FFFF, 32'hFFFF_FFFF);
        offer_request(CMD_SPARE_HI, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        wait_for_decodes();

        burst_left = 0;
        for (int i = 0; i < RANDOM_REQUESTS; i++)
        begin
            if (i == RANDOM_REQUESTS / 3)
            begin
                hold_requests++;
                burst_left = 64;
            end
            else if (i == 2 * RANDOM_REQUESTS / 3)
            begin
                wait_for_decodes();
            end
            if (burst_left == 0)
            begin
                idle_sender($urandom_range(1, 12));
                burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                         : $urandom_range(1, 20);
            end
            burst_left--;
            pick_random_request(cmd, op);
            offer_request(cmd, op, $urandom);
        end

        wait_for_decodes();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (decode_sb.mismatch_count == 0 && decode_sb.pending_count() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
